FILE: src/hbsd_pkg.sv
// Package for the HTTP body stream decoder: request and result types,
// operation and status codes, register map and character helpers.
// No dependencies.
`timescale 1ns / 1ps

package hbsd_pkg;

  localparam int unsigned CFG_ADDR_W  = 3;
  localparam int unsigned MAX_BODY_W  = 32;
  localparam int unsigned MAX_TRL_W   = 22;
  localparam int unsigned LENGTH_W    = 64;
  localparam int unsigned IN_DATA_W   = 72;
  localparam int unsigned OUT_DATA_W  = 16;

  localparam logic [MAX_BODY_W-1:0] RESET_MAX_BODY    = 32'(8 * 1024 * 1024);
  localparam logic [MAX_TRL_W-1:0]  RESET_MAX_TRAILER = 22'(64 * 1024);

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  typedef enum logic [1:0] {
    OP_BYTE          = 2'd0,
    OP_START_FIXED   = 2'd1,
    OP_START_CHUNKED = 2'd2,
    OP_ABORT         = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_BUSY  = 2'd1,
    ST_DONE  = 2'd2,
    ST_ERROR = 2'd3
  } status_t;

  typedef enum logic {
    REG_MAX_BODY    = 1'b0,
    REG_MAX_TRAILER = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t                 op;
    logic [7:0]          byte_value;
    logic [LENGTH_W-1:0] length;
  } hbsd_item_t;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    status_t    status;
  } hbsd_result_t;

  typedef struct packed {
    logic [MAX_BODY_W-1:0] max_body;
    logic [MAX_TRL_W-1:0]  max_trailer;
  } hbsd_cfg_t;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic is_ows(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

endpackage

FILE: src/hbsd_cfg.sv
// Configuration registers of the HTTP body stream decoder, APB-style port.
// Depends on hbsd_pkg.
`timescale 1ns / 1ps

module hbsd_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [hbsd_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                      cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready,
  output hbsd_pkg::hbsd_cfg_t              cfg
);
  import hbsd_pkg::*;

  logic [MAX_BODY_W-1:0] max_body_r;
  logic [MAX_TRL_W-1:0]  max_trailer_r;
  reg_idx_t              idx;
  logic                  wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r    <= RESET_MAX_BODY;
      max_trailer_r <= RESET_MAX_TRAILER;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAX_BODY:    max_body_r    <= cfg_pwdata;
        REG_MAX_TRAILER: max_trailer_r <= cfg_pwdata[MAX_TRL_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_BODY:    cfg_prdata = max_body_r;
      REG_MAX_TRAILER: cfg_prdata = {{(32 - MAX_TRL_W){1'b0}}, max_trailer_r};
    endcase
  end

  assign cfg.max_body    = max_body_r;
  assign cfg.max_trailer = max_trailer_r;

endmodule

FILE: src/hbsd_core.sv
// Body deframing state and per-request update: fixed-length count, chunk
// size line parse, chunk data and CRLF checks, trailer line checks.
// Depends on hbsd_pkg.
`timescale 1ns / 1ps

module hbsd_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  input  hbsd_pkg::hbsd_item_t   item,
  input  hbsd_pkg::hbsd_cfg_t    cfg,
  output hbsd_pkg::hbsd_result_t result
);
  import hbsd_pkg::*;

  typedef enum logic [2:0] {
    MODE_NONE    = 3'b001,
    MODE_FIXED   = 3'b010,
    MODE_CHUNKED = 3'b100
  } mode_t;

  typedef enum logic [4:0] {
    PH_SIZE    = 5'b00001,
    PH_DATA    = 5'b00010,
    PH_DCR     = 5'b00100,
    PH_DLF     = 5'b01000,
    PH_TRAILER = 5'b10000
  } phase_t;

  typedef struct packed {
    logic digit;
    logic tail;
    logic ext;
    logic cr;
  } size_flags_t;

  typedef struct packed {
    logic content;
    logic colon;
    logic cr;
  } trl_flags_t;

  mode_t                 mode_r, mode_nxt;
  phase_t                phase_r, phase_nxt;
  logic [LENGTH_W-1:0]   bytes_left_r, bytes_left_nxt;
  logic [MAX_BODY_W-1:0] size_accum_r, size_accum_nxt;
  size_flags_t           sf_r, sf_nxt;
  logic [MAX_BODY_W-1:0] decoded_r, decoded_nxt;
  logic [MAX_TRL_W:0]    trl_total_r, trl_total_nxt;
  trl_flags_t            tf_r, tf_nxt;
  logic                  failed_r, failed_nxt;

  logic [7:0]            c;
  logic                  is_cr, is_lf, is_colon, is_semi, is_sp;
  logic [4:0]            hex;
  logic [MAX_BODY_W-1:0] acc_shift;
  logic                  acc_over;
  logic [MAX_BODY_W:0]   line_sum;
  logic                  line_bad;
  logic [MAX_TRL_W:0]    trl_inc;
  logic                  trl_over;
  logic [LENGTH_W-1:0]   left_dec;
  logic                  dv, done, err;

  assign c         = item.byte_value;
  assign is_cr     = (c == CH_CR);
  assign is_lf     = (c == CH_LF);
  assign is_colon  = (c == CH_COLON);
  assign is_semi   = (c == CH_SEMI);
  assign is_sp     = is_ows(c);
  assign hex       = hex_digit(c);
  assign acc_shift = {size_accum_r[MAX_BODY_W-5:0], hex[3:0]};
  assign acc_over  = (|size_accum_r[MAX_BODY_W-1:MAX_BODY_W-4]) || (acc_shift > cfg.max_body);
  assign line_sum  = {1'b0, decoded_r} + {1'b0, size_accum_r};
  assign line_bad  = !sf_r.digit || (size_accum_r > cfg.max_body)
                     || (line_sum > {1'b0, cfg.max_body});
  assign trl_inc   = trl_total_r + 1'b1;
  assign trl_over  = trl_inc > {1'b0, cfg.max_trailer};
  assign left_dec  = bytes_left_r - 1'b1;

  always_comb begin
    mode_nxt       = mode_r;
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    size_accum_nxt = size_accum_r;
    sf_nxt         = sf_r;
    decoded_nxt    = decoded_r;
    trl_total_nxt  = trl_total_r;
    tf_nxt         = tf_r;
    failed_nxt     = failed_r;
    dv             = 1'b0;
    done           = 1'b0;
    err            = 1'b0;

    if (item.op != OP_BYTE) begin
      mode_nxt       = MODE_NONE;
      phase_nxt      = PH_SIZE;
      bytes_left_nxt = '0;
      size_accum_nxt = '0;
      sf_nxt         = '0;
      decoded_nxt    = '0;
      trl_total_nxt  = '0;
      tf_nxt         = '0;
      failed_nxt     = 1'b0;
    end

    unique case (item.op)
      OP_ABORT: ;
      OP_START_FIXED: begin
        if (item.length == '0) begin
          done = 1'b1;
        end else begin
          mode_nxt       = MODE_FIXED;
          bytes_left_nxt = item.length;
        end
      end
      OP_START_CHUNKED: mode_nxt = MODE_CHUNKED;
      OP_BYTE: begin
        if (!failed_r) begin
          unique case (mode_r)
            MODE_NONE: ;
            MODE_FIXED: begin
              dv             = 1'b1;
              bytes_left_nxt = left_dec;
              if (left_dec == '0) begin
                mode_nxt = MODE_NONE;
                done     = 1'b1;
              end
            end
            MODE_CHUNKED: begin
              unique case (phase_r)
                PH_SIZE: begin
                  if (sf_r.cr) begin
                    if (is_lf) begin
                      if (line_bad) begin
                        err = 1'b1;
                      end else begin
                        bytes_left_nxt = {{(LENGTH_W - MAX_BODY_W){1'b0}}, size_accum_r};
                        size_accum_nxt = '0;
                        sf_nxt         = '0;
                        tf_nxt         = '0;
                        phase_nxt      = (size_accum_r == '0) ? PH_TRAILER : PH_DATA;
                      end
                    end else if (!sf_r.ext) begin
                      err = 1'b1;
                    end else begin
                      sf_nxt.cr = is_cr;
                    end
                  end else if (is_cr) begin
                    sf_nxt.cr = 1'b1;
                  end else if (sf_r.ext) begin
                    sf_nxt.ext = 1'b1;
                  end else if (is_semi) begin
                    sf_nxt.ext = 1'b1;
                  end else if (is_sp) begin
                    if (sf_r.digit) begin
                      sf_nxt.tail = 1'b1;
                    end
                  end else if (!hex[4] || sf_r.tail || acc_over) begin
                    err = 1'b1;
                  end else begin
                    size_accum_nxt = acc_shift;
                    sf_nxt.digit   = 1'b1;
                  end
                end
                PH_DATA: begin
                  dv             = 1'b1;
                  decoded_nxt    = decoded_r + 1'b1;
                  bytes_left_nxt = left_dec;
                  if (left_dec == '0) begin
                    phase_nxt = PH_DCR;
                  end
                end
                PH_DCR: begin
                  if (!is_cr) begin
                    err = 1'b1;
                  end else begin
                    phase_nxt = PH_DLF;
                  end
                end
                PH_DLF: begin
                  if (!is_lf) begin
                    err = 1'b1;
                  end else begin
                    phase_nxt      = PH_SIZE;
                    size_accum_nxt = '0;
                    sf_nxt         = '0;
                  end
                end
                PH_TRAILER: begin
                  trl_total_nxt = trl_inc;
                  if (trl_over) begin
                    err = 1'b1;
                  end else if (tf_r.cr) begin
                    if (is_lf) begin
                      if (!tf_r.content) begin
                        done     = 1'b1;
                        mode_nxt = MODE_NONE;
                      end else if (!tf_r.colon) begin
                        err = 1'b1;
                      end else begin
                        tf_nxt = '0;
                      end
                    end else begin
                      tf_nxt.content = 1'b1;
                      tf_nxt.colon   = tf_r.colon || is_colon;
                      tf_nxt.cr      = is_cr;
                    end
                  end else if (is_cr) begin
                    tf_nxt.cr = 1'b1;
                  end else if (!tf_r.content) begin
                    if (is_sp || is_colon) begin
                      err = 1'b1;
                    end else begin
                      tf_nxt.content = 1'b1;
                    end
                  end else if (is_colon) begin
                    tf_nxt.colon = 1'b1;
                  end
                end
                default: err = 1'b1;
              endcase
            end
            default: ;
          endcase
        end
      end
    endcase

    if (err) begin
      failed_nxt = 1'b1;
      mode_nxt   = MODE_NONE;
      dv         = 1'b0;
    end
  end

  always_comb begin
    result.data_valid = dv;
    result.data_byte  = dv ? c : 8'd0;
    if (failed_nxt) begin
      result.status = ST_ERROR;
    end else if (done) begin
      result.status = ST_DONE;
    end else if (mode_nxt != MODE_NONE) begin
      result.status = ST_BUSY;
    end else begin
      result.status = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_NONE;
      phase_r      <= PH_SIZE;
      bytes_left_r <= '0;
      size_accum_r <= '0;
      sf_r         <= '0;
      decoded_r    <= '0;
      trl_total_r  <= '0;
      tf_r         <= '0;
      failed_r     <= 1'b0;
    end else if (step_en) begin
      mode_r       <= mode_nxt;
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      size_accum_r <= size_accum_nxt;
      sf_r         <= sf_nxt;
      decoded_r    <= decoded_nxt;
      trl_total_r  <= trl_total_nxt;
      tf_r         <= tf_nxt;
      failed_r     <= failed_nxt;
    end
  end

endmodule

FILE: src/http_body_stream_decoder.sv
// HTTP body stream decoder: takes one request per clock while the output is
// not stalled (start fixed-length, start chunked, abort or one body byte), and
// returns exactly one result per request. A request is held in the input
// register and its result in the result register; hbsd_core updates its
// state once per request. Status reads 2 only on the request that completes
// a body and 3 from the first error until the next start or abort. Write
// max_body and max_trailer only while no request is in flight.
// Depends on hbsd_pkg, hbsd_cfg and hbsd_core.
`timescale 1ns / 1ps

module http_body_stream_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [hbsd_pkg::IN_DATA_W-1:0]  in_tdata,   // byte_value[7:0], length[71:8]
  input  logic [1:0]                      in_tuser,   // operation[1:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hbsd_pkg::OUT_DATA_W-1:0] out_tdata,  // data_byte[7:0], status[9:8]
  output logic                            out_tuser,  // data_valid
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [hbsd_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                     cfg_pwdata,
  output logic [31:0]                     cfg_prdata,
  output logic                            cfg_pready
);
  import hbsd_pkg::*;

  hbsd_cfg_t    cfg;
  hbsd_item_t   s1_item_r;
  logic         s1_valid_r;
  hbsd_result_t res;
  hbsd_result_t out_res_r;
  logic         out_valid_r;
  logic         advance;
  logic         step_en;

  hbsd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  assign advance   = !out_valid_r || out_tready;
  assign step_en   = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.op         <= op_t'(in_tuser);
      s1_item_r.byte_value <= in_tdata[7:0];
      s1_item_r.length     <= in_tdata[IN_DATA_W-1:8];
    end
  end

  hbsd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (step_en),
    .item    (s1_item_r),
    .cfg     (cfg),
    .result  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.data_valid;
  assign out_tdata  = {{(OUT_DATA_W - 10){1'b0}}, out_res_r.status, out_res_r.data_byte};

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for http_body_stream_decoder: fixed-length and chunked bodies,
// malformed framing, register limits and output stalls, checked against an in-bench decoder.
// Depends on hbsd_pkg and the http_body_stream_decoder RTL.
`timescale 1ns / 1ps

module tb_top;
  import hbsd_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int STALL_CYCLES = 300;
  localparam string CRLF = "\015\012";

  typedef enum logic [1:0] {BODY_NONE, BODY_FIXED, BODY_CHUNKED} body_state_t;
  typedef enum logic [2:0] {PH_SIZE, PH_DATA, PH_DCR, PH_DLF, PH_TRAILER} parse_phase_t;
  typedef enum {STEP_OK, STEP_FAIL, STEP_DONE} step_t;
  typedef enum {
    FLT_NONE, FLT_SIZE_JUNK, FLT_SIZE_HUGE, FLT_NO_DIGITS, FLT_DATA_CRLF,
    FLT_TRAILER_LEAD, FLT_TRAILER_NO_COLON, FLT_ABORT, FLT_TRUNCATE
  } fault_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;   // byte_value[7:0], length[71:8]
  logic [1:0] in_tuser = '0;             // operation[1:0]
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;      // data_byte[7:0], status[9:8]
  logic out_tuser;                       // data_valid
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic rx_hold = 1'b0;
  int requests_sent = 0;
  int results_checked = 0;
  int fail_count = 0;
  int quiet_cycles = 0;
  hbsd_result_t body_results[$];

  logic [31:0] lim_body;
  logic [21:0] lim_trailer;
  body_state_t body_state;
  parse_phase_t parse_phase;
  logic [63:0] remaining;
  logic [63:0] size_acc;
  bit sz_digit, sz_tail, sz_ext, sz_cr;
  logic [31:0] body_total;
  logic [31:0] trailer_count;
  bit tl_content, tl_colon, tl_cr;
  bit failed;

  http_body_stream_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_body();
    body_state = BODY_NONE;
    parse_phase = PH_SIZE;
    remaining = '0;
    size_acc = '0;
    {sz_digit, sz_tail, sz_ext, sz_cr} = '0;
    body_total = '0;
    trailer_count = '0;
    {tl_content, tl_colon, tl_cr} = '0;
    failed = 1'b0;
  endfunction

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c - "0";
    if (c >= "a" && c <= "f") return c - "a" + 10;
    if (c >= "A" && c <= "F") return c - "A" + 10;
    return -1;
  endfunction

  function automatic bit size_byte_ok(input logic [7:0] c);
    int d;
    if (sz_ext) return 1'b1;
    if (c == CH_SEMI) begin
      sz_ext = 1'b1;
      return 1'b1;
    end
    if (c == CH_SP || c == CH_TAB) begin
      if (sz_digit) sz_tail = 1'b1;
      return 1'b1;
    end
    d = hex_value(c);
    if (d < 0 || sz_tail) return 1'b0;
    size_acc = (size_acc << 4) | 64'(d);
    if (size_acc > {32'd0, lim_body}) return 1'b0;
    sz_digit = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit size_line_close();
    if (!sz_digit) return 1'b0;
    if (size_acc > {32'd0, lim_body}) return 1'b0;
    if ({32'd0, body_total} > {32'd0, lim_body} - size_acc) return 1'b0;
    remaining = size_acc;
    parse_phase = (size_acc == 64'd0) ? PH_TRAILER : PH_DATA;
    size_acc = '0;
    {sz_digit, sz_tail, sz_ext, sz_cr} = '0;
    {tl_content, tl_colon, tl_cr} = '0;
    return 1'b1;
  endfunction

  function automatic bit trailer_byte_ok(input logic [7:0] c);
    if (!tl_content) begin
      if (c == CH_SP || c == CH_TAB || c == CH_COLON) return 1'b0;
      tl_content = 1'b1;
    end else if (c == CH_COLON) begin
      tl_colon = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic step_t chunk_byte(input logic [7:0] c, output bit dv);
    dv = 1'b0;
    case (parse_phase)
      PH_SIZE: begin
        if (sz_cr && c == CH_LF) return size_line_close() ? STEP_OK : STEP_FAIL;
        if (sz_cr) begin
          sz_cr = 1'b0;
          if (!size_byte_ok(CH_CR)) return STEP_FAIL;
        end
        if (c == CH_CR) begin
          sz_cr = 1'b1;
          return STEP_OK;
        end
        return size_byte_ok(c) ? STEP_OK : STEP_FAIL;
      end
      PH_DATA: begin
        dv = 1'b1;
        body_total++;
        remaining--;
        if (remaining == 64'd0) parse_phase = PH_DCR;
        return STEP_OK;
      end
      PH_DCR: begin
        if (c != CH_CR) return STEP_FAIL;
        parse_phase = PH_DLF;
        return STEP_OK;
      end
      PH_DLF: begin
        if (c != CH_LF) return STEP_FAIL;
        parse_phase = PH_SIZE;
        size_acc = '0;
        {sz_digit, sz_tail, sz_ext, sz_cr} = '0;
        return STEP_OK;
      end
      PH_TRAILER: begin
        trailer_count++;
        if (trailer_count > {10'd0, lim_trailer}) return STEP_FAIL;
        if (tl_cr && c == CH_LF) begin
          if (!tl_content) return STEP_DONE;
          if (!tl_colon) return STEP_FAIL;
          {tl_content, tl_colon, tl_cr} = '0;
          return STEP_OK;
        end
        if (tl_cr) begin
          tl_cr = 1'b0;
          if (!trailer_byte_ok(CH_CR)) return STEP_FAIL;
        end
        if (c == CH_CR) begin
          tl_cr = 1'b1;
          return STEP_OK;
        end
        return trailer_byte_ok(c) ? STEP_OK : STEP_FAIL;
      end
      default: return STEP_FAIL;
    endcase
  endfunction

  function automatic hbsd_result_t decode_request(input op_t op, input logic [7:0] c,
                                                  input logic [63:0] len);
    hbsd_result_t r;
    bit dv;
    bit done;
    step_t s;
    dv = 1'b0;
    done = 1'b0;
    case (op)
      OP_ABORT: clear_body();
      OP_START_FIXED: begin
        clear_body();
        if (len == 64'd0) begin
          done = 1'b1;
        end else begin
          body_state = BODY_FIXED;
          remaining = len;
        end
      end
      OP_START_CHUNKED: begin
        clear_body();
        body_state = BODY_CHUNKED;
      end
      default: begin
        if (!failed && body_state == BODY_FIXED) begin
          dv = 1'b1;
          remaining--;
          if (remaining == 64'd0) begin
            body_state = BODY_NONE;
            done = 1'b1;
          end
        end else if (!failed && body_state == BODY_CHUNKED) begin
          s = chunk_byte(c, dv);
          if (s == STEP_FAIL) begin
            failed = 1'b1;
            body_state = BODY_NONE;
            dv = 1'b0;
          end else if (s == STEP_DONE) begin
            body_state = BODY_NONE;
            done = 1'b1;
          end
        end
      end
    endcase
    r.data_valid = dv;
    r.data_byte = dv ? c : 8'h00;
    if (failed) r.status = ST_ERROR;
    else if (done) r.status = ST_DONE;
    else if (body_state != BODY_NONE) r.status = ST_BUSY;
    else r.status = ST_IDLE;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      body_results.push_back(decode_request(op_t'(in_tuser), in_tdata[7:0], in_tdata[71:8]));
  end

  always @(posedge clk) begin : check_result
    hbsd_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked++;
      if (body_results.size() == 0) begin
        $error("result with no request pending: data_valid %0b data_byte %0h status %0d",
               out_tuser, out_tdata[7:0], out_tdata[9:8]);
        fail_count++;
      end else begin
        want = body_results.pop_front();
        if (out_tuser !== want.data_valid) begin
          $error("data_valid: expected %0b, got %0b", want.data_valid, out_tuser);
          fail_count++;
        end
        if (out_tdata[7:0] !== want.data_byte) begin
          $error("data_byte: expected %0h, got %0h", want.data_byte, out_tdata[7:0]);
          fail_count++;
        end
        if (out_tdata[9:8] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_tdata[9:8]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no request or result moved for %0d cycles", QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [63:0] rand_len();
    return {$urandom, $urandom};
  endfunction

  function automatic string blank_run();
    case ($urandom_range(0, 2))
      0: return " ";
      1: return "\t";
      default: return " \t";
    endcase
  endfunction

  function automatic logic [7:0] pick_char();
    string hexset;
    hexset = "0123456789abcdefABCDEF";
    case ($urandom_range(0, 8))
      0: return CH_CR;
      1: return CH_LF;
      2: return CH_COLON;
      3: return CH_SEMI;
      4: return CH_SP;
      5: return CH_TAB;
      6, 7: return hexset[$urandom_range(0, 21)];
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic string size_line(input logic [31:0] size);
    string s;
    string digits;
    digits = $sformatf("%0h", size);
    for (int i = 0; i < digits.len(); i++) begin
      if (digits[i] >= "a" && $urandom_range(0, 1) == 1) digits[i] = digits[i] - 8'd32;
    end
    if ($urandom_range(0, 3) == 0) digits = {"0", digits};
    s = "";
    if ($urandom_range(0, 3) == 0) s = blank_run();
    s = {s, digits};
    if ($urandom_range(0, 3) == 0) s = {s, blank_run()};
    if ($urandom_range(0, 2) == 0) s = {s, ";ext=", ($urandom_range(0, 1) ? "a\015b" : "v")};
    return {s, CRLF};
  endfunction

  function automatic string trailer_line();
    string s;
    s = "X-";
    repeat ($urandom_range(1, 4)) s = {s, $sformatf("%c", 8'($urandom_range(97, 122)))};
    s = {s, ":"};
    if ($urandom_range(0, 1) == 1) s = {s, " "};
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 5))
        0: s = {s, ":"};
        1: s = {s, "\015"};
        default: s = {s, $sformatf("%c", 8'($urandom_range(33, 126)))};
      endcase
    end
    return {s, CRLF};
  endfunction

  task automatic send_request(input op_t op, input logic [7:0] b, input logic [63:0] len);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {len, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    requests_sent++;
  endtask

  task automatic send_byte(input logic [7:0] c);
    send_request(OP_BYTE, c, rand_len());
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (body_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (idx == REG_MAX_BODY) lim_body = value;
    else lim_trailer = value[21:0];
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_limits(input logic [31:0] body, input logic [31:0] trailer);
    wait_drained();
    write_reg(REG_MAX_BODY, body);
    write_reg(REG_MAX_TRAILER, trailer);
  endtask

  task automatic send_chunked_body(input fault_t flt);
    int chunks;
    int where;
    int size;
    chunks = $urandom_range(1, 4);
    where = $urandom_range(0, chunks - 1);
    send_request(OP_START_CHUNKED, 8'($urandom), rand_len());
    for (int k = 0; k < chunks; k++) begin
      if (k == where) begin
        case (flt)
          FLT_SIZE_JUNK: begin
            case ($urandom_range(0, 3))
              0: send_text({"1g", CRLF});
              1: send_text({"1 2", CRLF});
              2: send_text({"\0151", CRLF});
              default: send_text({"1:", CRLF});
            endcase
            return;
          end
          FLT_SIZE_HUGE: begin
            send_text({"1000000000", CRLF});
            return;
          end
          FLT_NO_DIGITS: begin
            send_text($urandom_range(0, 1) ? CRLF : {" ;x", CRLF});
            return;
          end
          FLT_ABORT: begin
            send_request(OP_ABORT, 8'($urandom), rand_len());
            return;
          end
          FLT_TRUNCATE: return;
          default: ;
        endcase
      end
      size = $urandom_range(1, 12);
      send_text(size_line(size));
      repeat (size) send_byte(8'($urandom));
      if (k == where && flt == FLT_DATA_CRLF) begin
        case ($urandom_range(0, 2))
          0: send_text("X");
          1: send_text("\015X");
          default: send_text("\012");
        endcase
        return;
      end
      send_text(CRLF);
    end
    send_text(size_line(0));
    repeat ($urandom_range(0, 2)) send_text(trailer_line());
    if (flt == FLT_TRAILER_LEAD) begin
      case ($urandom_range(0, 2))
        0: send_text({" ", trailer_line()});
        1: send_text({"\t", trailer_line()});
        default: send_text({":", trailer_line()});
      endcase
      return;
    end
    if (flt == FLT_TRAILER_NO_COLON) begin
      send_text({"Xname value", CRLF});
      return;
    end
    send_text(CRLF);
  endtask

  task automatic test_directed();
    send_request(OP_START_FIXED, 8'hFF, 64'd0);
    send_request(OP_START_FIXED, 8'h00, '1);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_request(OP_ABORT, 8'h5A, '0);
    send_byte(8'hA5);
    send_request(OP_START_CHUNKED, 8'h00, '0);
    send_text("1;\015\015\012");
    send_byte("A");
    send_text(CRLF);
    send_text({"0", CRLF, CRLF});
    send_request(OP_START_CHUNKED, 8'hFF, '1);
    send_byte("g");
    send_byte(8'h00);
    send_request(OP_ABORT, 8'hFF, '1);
  endtask

  task automatic test_fixed_bodies(input int budget);
    int stop;
    int n;
    bit huge;
    logic [63:0] len;
    stop = requests_sent + budget;
    while (requests_sent < stop) begin
      huge = 1'b0;
      case ($urandom_range(0, 9))
        0: begin
          len = rand_len();
          huge = 1'b1;
        end
        1: len = 64'd0;
        default: len = $urandom_range(1, 16);
      endcase
      send_request(OP_START_FIXED, 8'($urandom), len);
      n = huge ? $urandom_range(1, 4) : int'(len);
      if (!huge && n > 0 && $urandom_range(0, 7) == 0) n = $urandom_range(0, n - 1);
      repeat (n) send_byte(8'($urandom));
      if (huge || n < len) begin
        if ($urandom_range(0, 1) == 1) send_request(OP_ABORT, 8'($urandom), rand_len());
      end else if ($urandom_range(0, 5) == 0) begin
        send_byte(8'($urandom));
      end
    end
  endtask

  task automatic test_chunked_bodies(input int budget);
    int stop;
    stop = requests_sent + budget;
    while (requests_sent < stop) send_chunked_body(FLT_NONE);
  endtask

  task automatic test_chunked_faults(input int budget);
    int stop;
    stop = requests_sent + budget;
    while (requests_sent < stop) begin
      send_chunked_body(fault_t'($urandom_range(FLT_SIZE_JUNK, FLT_TRUNCATE)));
      if ($urandom_range(0, 3) == 0) send_byte(pick_char());
    end
  endtask

  task automatic test_noise(input int budget);
    int stop;
    stop = requests_sent + budget;
    while (requests_sent < stop) begin
      case ($urandom_range(0, 19))
        0: send_request(OP_START_FIXED, 8'($urandom), $urandom_range(0, 3));
        1: send_request(OP_START_CHUNKED, 8'($urandom), rand_len());
        2: send_request(OP_ABORT, 8'($urandom), rand_len());
        default: send_byte(pick_char());
      endcase
    end
  endtask

  task automatic test_register_extremes();
    apply_limits(32'd0, 32'd0);
    send_request(OP_START_CHUNKED, 8'($urandom), rand_len());
    send_text({"0", CRLF, CRLF});
    send_chunked_body(FLT_NONE);
    send_request(OP_START_FIXED, 8'($urandom), 64'd0);
    apply_limits(32'd0, 32'd2);
    send_request(OP_START_CHUNKED, 8'($urandom), rand_len());
    send_text({"0", CRLF, CRLF});
    apply_limits(RESET_MAX_BODY, 32'(RESET_MAX_TRAILER));
    send_chunked_body(FLT_NONE);
  endtask

  task automatic test_backpressure();
    rx_hold <= 1'b1;
    fork
      begin
        repeat (STALL_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
      end
    join_none
    send_request(OP_START_FIXED, 8'($urandom), 64'd40);
    repeat (40) send_byte(8'($urandom));
  endtask

  initial begin
    lim_body = RESET_MAX_BODY;
    lim_trailer = RESET_MAX_TRAILER;
    clear_body();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 15;
    rx_idle_pct = 65;
    test_directed();
    for (int round = 0; round < 3; round++) begin
      case (round)
        0: apply_limits($urandom, $urandom);
        1: apply_limits(32'd48, 32'd40);
        default: apply_limits(32'hFFFF_FFFF, 32'h003F_FFFF);
      endcase
      tx_idle_pct = (round == 0) ? 15 : (round == 1) ? 65 : 0;
      rx_idle_pct = (round == 0) ? 65 : (round == 1) ? 15 : 0;
      test_fixed_bodies(60);
      test_chunked_bodies(90);
      test_chunked_faults(70);
      test_noise(30);
    end
    test_backpressure();
    test_register_extremes();
    wait_drained();
    repeat (10) @(posedge clk);
    $display("Sent %0d requests, checked %0d results", requests_sent, results_checked);
    $display("Covered fixed and chunked bodies, malformed framing, limits and output stalls");
    if (fail_count == 0 && body_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
